FILE: src/waveform_table_generator_macros.svh
// assertion helpers shared by the waveform table generator rtl
// each macro expects clk and arst_n in the enclosing module
`ifndef WAVEFORM_TABLE_GENERATOR_MACROS_SVH
`define WAVEFORM_TABLE_GENERATOR_MACROS_SVH

// same-cycle implication
`define WTG_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WTG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/wtg_pkg.sv
`default_nettype none

package wtg_pkg;

	// sizing and scaling constants
	localparam int unsigned WAVE_LENGTH_DEF = 400;
	localparam int unsigned MAX_DUTY_COUNT  = 100;
	localparam int unsigned TRIGGER_WIDTH   = 20;
	localparam int unsigned AMP_FULL        = 33;
	localparam int unsigned DUTY_FULL       = 100;
	localparam int unsigned DEG_FULL        = 360;
	localparam logic [6:0]  DUTY_RESET      = 7'd50;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int unsigned SINE_W      = 16;
	localparam int unsigned ARB_NUM_W   = 14;
	localparam int unsigned AMP_DEN_W   = 6;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 9;

	// reciprocal of the full amplitude, exact for dividends below 2**15
	localparam int unsigned ARB_RECIP_SHIFT = 16;
	localparam int unsigned ARB_RECIP       = ((1 << ARB_RECIP_SHIFT) + AMP_FULL - 1) / AMP_FULL;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_RESTART = 2'd1,
		OP_LOAD    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		SHAPE_OFF       = 3'd0,
		SHAPE_SINE      = 3'd1,
		SHAPE_SQUARE    = 3'd2,
		SHAPE_TRIANGLE  = 3'd3,
		SHAPE_ARBITRARY = 3'd4
	} wave_t;

	typedef enum logic [1:0] {
		REG_WAVE_TYPE     = 2'd0,
		REG_AMPLITUDE     = 2'd1,
		REG_DUTY_PERCENT  = 2'd2,
		REG_PHASE_DEGREES = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CALC,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] sample_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] duty_value;
		logic       trigger;
	} result_t;

	// load side commands for the sample store
	typedef struct packed {
		logic       restart;
		logic       load;
		logic [7:0] sample_byte;
	} store_cmd_t;

	// peak duty count for each clamped amplitude
	typedef logic [7:0] peak_table_t [AMP_FULL+1];

	function automatic peak_table_t build_peak_table();
		peak_table_t tbl;
		for (int unsigned i = 0; i <= AMP_FULL; i++) begin
			tbl[i] = 8'(i * MAX_DUTY_COUNT / AMP_FULL);
		end
		return tbl;
	endfunction

	localparam peak_table_t PEAK_TABLE = build_peak_table();

endpackage

`default_nettype wire

FILE: src/wtg_divider.sv
`default_nettype none

module wtg_divider #(
	parameter int unsigned NUM_W = wtg_pkg::ARB_NUM_W,
	parameter int unsigned DEN_W = wtg_pkg::AMP_DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             busy,
	output logic [NUM_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             ge;

	// one quotient bit per cycle, restoring
	assign shifted  = {rem_q, quo_q[NUM_W-1]};
	assign ge       = shifted >= {1'b0, den_q};
	assign diff     = shifted - {1'b0, den_q};
	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= denom;
			quo_q <= numer;
		end else if (busy) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

FILE: src/wtg_sample_store.sv
`default_nettype none

module wtg_sample_store #(
	parameter int unsigned WAVE_LENGTH = wtg_pkg::WAVE_LENGTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wtg_pkg::store_cmd_t            cmd,
	input  logic                           rd_en,
	input  logic [$clog2(WAVE_LENGTH)-1:0] rd_addr,
	output logic [7:0]                     rd_data
);

	localparam int unsigned IDX_W = $clog2(WAVE_LENGTH);
	localparam int unsigned CNT_W = $clog2(WAVE_LENGTH + 1);

	logic [7:0]       mem [WAVE_LENGTH];
	logic [CNT_W-1:0] load_index_q;
	logic [CNT_W-1:0] fill_q;
	logic [7:0]       data_q;
	logic             hit_q;
	logic             write_en;

	// bytes past the end are dropped
	assign write_en = cmd.load && (load_index_q < CNT_W'(WAVE_LENGTH));

	// load pointer and high-water mark; entries at or above the mark read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_index_q <= '0;
			fill_q       <= '0;
		end else if (cmd.restart) begin
			load_index_q <= '0;
		end else if (write_en) begin
			load_index_q <= load_index_q + 1'b1;
			if (load_index_q == fill_q) begin
				fill_q <= load_index_q + 1'b1;
			end
		end
	end

	// sample ram, one write and one registered read port
	always_ff @(posedge clk) begin
		if (write_en) begin
			mem[load_index_q[IDX_W-1:0]] <= cmd.sample_byte;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
			hit_q  <= CNT_W'(rd_addr) < fill_q;
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

`default_nettype wire

FILE: src/wtg_sine_rom.sv
`default_nettype none

module wtg_sine_rom #(
	parameter int unsigned WAVE_LENGTH = wtg_pkg::WAVE_LENGTH_DEF
) (
	input  logic                               clk,
	input  logic                               rd_en,
	input  logic [$clog2(WAVE_LENGTH)-1:0]     rd_addr,
	output logic signed [wtg_pkg::SINE_W-1:0]  rd_data
);

	typedef logic signed [wtg_pkg::SINE_W-1:0] rom_t [WAVE_LENGTH];

	// q1.15 sine of one period point: quadrant fold, then odd taylor series to x^9 in q30
	function automatic logic signed [wtg_pkg::SINE_W-1:0] sine_entry(input int unsigned n);
		longint unsigned q;
		longint unsigned quad;
		longint unsigned r;
		longint unsigned t;
		longint unsigned t2;
		longint unsigned term;
		longint          sum;
		q    = 64'(n) * 64'd4;
		quad = q / WAVE_LENGTH;
		r    = q % WAVE_LENGTH;
		if (quad[0]) begin
			r = WAVE_LENGTH - r;
		end
		t    = (r * wtg_pkg::HALF_PI_Q30) / WAVE_LENGTH;
		t2   = (t * t) >> 30;
		sum  = longint'(t);
		term = ((t * t2) >> 30) / 6;
		sum  = sum - longint'(term);
		term = ((term * t2) >> 30) / 20;
		sum  = sum + longint'(term);
		term = ((term * t2) >> 30) / 42;
		sum  = sum - longint'(term);
		term = ((term * t2) >> 30) / 72;
		sum  = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		sum = (sum + 16384) >>> 15;
		if (sum > 32767) begin
			sum = 32767;
		end
		return quad[1] ? -wtg_pkg::SINE_W'(sum) : wtg_pkg::SINE_W'(sum);
	endfunction

	function automatic rom_t build_rom();
		rom_t rom;
		for (int unsigned i = 0; i < WAVE_LENGTH; i++) begin
			rom[i] = sine_entry(i);
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic signed [wtg_pkg::SINE_W-1:0] data_q;

	// registered rom read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= SINE_ROM[rd_addr];
		end
	end

	assign rd_data = data_q;

endmodule

`default_nettype wire

FILE: src/waveform_table_generator.sv
`default_nettype none

// Waveform table generator. Each tick transfer on the item channel returns one result
// transfer with the duty count of the current sample index and the trigger level, then
// steps the index around a period of WAVE_LENGTH samples. Restart and load transfers fill
// the arbitrary sample ram and give no result. Items are taken one at a time. An off,
// sine, square or arbitrary tick passes from idle through the fetch, calc and done steps,
// loads the result register in the done step and then returns to idle to take the next
// item. A triangle tick runs the one-bit-per-cycle divider for its slope in a divide step
// between calc and done (the dividend has clog2(WAVE_LENGTH) + 8 bits for lengths above
// 32). A tick stays in its last step while an earlier result still waits at the output.
// The result register lets the next item in while a result waits. The sample ram needs
// no clearing pass after reset: a high-water mark of the load pointer makes unloaded
// entries read as zero. Registers are to be written through the cfg channel only while
// no tick is in flight; the block does not enforce this.
module waveform_table_generator #(
	parameter int unsigned WAVE_LENGTH = wtg_pkg::WAVE_LENGTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  wtg_pkg::item_t                     item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output wtg_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wtg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wtg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	`include "waveform_table_generator_macros.svh"

	localparam int unsigned IDX_W  = $clog2(WAVE_LENGTH);
	localparam int unsigned CNT_W  = $clog2(WAVE_LENGTH + 1);
	localparam int unsigned MA_W   = (IDX_W > 8) ? IDX_W : 8;
	localparam int unsigned MB_W   = wtg_pkg::SINE_W + 1;
	localparam int unsigned PROD_W = MA_W + 1 + MB_W;
	localparam int unsigned TOT_W  = PROD_W + 1;
	localparam int unsigned NUM_W  = (IDX_W + 8 > wtg_pkg::ARB_NUM_W) ? IDX_W + 8
		: wtg_pkg::ARB_NUM_W;
	localparam int unsigned DEN_W  = (CNT_W > wtg_pkg::AMP_DEN_W) ? CNT_W
		: wtg_pkg::AMP_DEN_W;
	localparam int unsigned TRIG_W = CNT_W + 9;
	localparam int unsigned ARB_W  = wtg_pkg::ARB_NUM_W + wtg_pkg::ARB_RECIP_SHIFT;
	localparam logic signed [TOT_W-1:0] CEIL_BIAS = TOT_W'(65535);

	// duty percent to rise length in samples
	typedef logic [CNT_W-1:0] dix_table_t [wtg_pkg::DUTY_FULL+1];

	function automatic dix_table_t build_dix_table();
		dix_table_t tbl;
		for (int unsigned i = 0; i <= wtg_pkg::DUTY_FULL; i++) begin
			tbl[i] = CNT_W'(i * WAVE_LENGTH / wtg_pkg::DUTY_FULL);
		end
		return tbl;
	endfunction

	localparam dix_table_t DIX_TABLE = build_dix_table();

	wtg_pkg::state_t    state_q;
	wtg_pkg::state_t    state_d;
	wtg_pkg::store_cmd_t store_cmd;
	wtg_pkg::result_t   result_q;
	logic               result_valid_q;

	logic [2:0]         wave_type_q;
	logic [5:0]         amplitude_q;
	logic [6:0]         duty_percent_q;
	logic [8:0]         phase_degrees_q;

	logic [IDX_W-1:0]   play_index_q;
	logic [IDX_W:0]     idx_inc;
	logic [IDX_W-1:0]   next_index;
	logic [IDX_W-1:0]   idx_s1;
	logic signed [wtg_pkg::SINE_W-1:0] sine_s1;
	logic [7:0]         byte_s1;

	logic [5:0]         amp_c;
	logic [6:0]         duty_c;
	logic [8:0]         deg_c;
	logic [7:0]         peak;
	logic [CNT_W-1:0]   dix;
	logic               is_tri;
	logic               is_arb;

	logic               item_accept;
	logic               tick_accept;
	logic               cfg_accept;
	logic               out_free;

	logic               rise_now;
	logic [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [TRIG_W-1:0]  idx_ext;
	logic [TRIG_W-1:0]  phase_x;
	logic               low_ok;
	logic               high_ok;

	logic               rise_s2;
	logic               trig_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [TOT_W-1:0] total;
	logic signed [TOT_W-1:0] ceil_v;
	logic [7:0]         sine_duty;
	logic [ARB_W-1:0]   arb_scaled;
	logic [7:0]         arb_duty;
	logic [7:0]         direct_duty;
	logic [7:0]         div_duty;
	logic [7:0]         duty_s3;

	logic               div_start;
	logic               div_busy;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic [NUM_W-1:0]   div_quo;

	// handshakes
	assign item_accept = item_valid && item_ready;
	assign tick_accept = item_accept && (item.operation == wtg_pkg::OP_TICK);
	assign cfg_ready   = 1'b1;
	assign cfg_accept  = cfg_valid && cfg_ready;
	assign out_free    = !result_valid_q || result_ready;

	// register clamping and derived levels
	assign amp_c  = (amplitude_q > 6'(wtg_pkg::AMP_FULL)) ? 6'(wtg_pkg::AMP_FULL)
		: amplitude_q;
	assign duty_c = (duty_percent_q > 7'(wtg_pkg::DUTY_FULL)) ? 7'(wtg_pkg::DUTY_FULL)
		: duty_percent_q;
	assign deg_c  = (phase_degrees_q >= 9'(wtg_pkg::DEG_FULL)) ? '0 : phase_degrees_q;
	assign peak   = wtg_pkg::PEAK_TABLE[amp_c];
	assign dix    = DIX_TABLE[duty_c];
	assign is_tri = wave_type_q == wtg_pkg::SHAPE_TRIANGLE;
	assign is_arb = wave_type_q == wtg_pkg::SHAPE_ARBITRARY;

	// index step with wrap; the sine entry is read one sample ahead
	assign idx_inc    = {1'b0, play_index_q} + 1'b1;
	assign next_index = (idx_inc == (IDX_W+1)'(WAVE_LENGTH)) ? '0 : idx_inc[IDX_W-1:0];

	// load side of the sample ram
	assign store_cmd.restart     = item_accept && (item.operation == wtg_pkg::OP_RESTART);
	assign store_cmd.load        = item_accept && (item.operation == wtg_pkg::OP_LOAD);
	assign store_cmd.sample_byte = item.sample_byte;

	wtg_sample_store #(
		.WAVE_LENGTH (WAVE_LENGTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (store_cmd),
		.rd_en   (tick_accept),
		.rd_addr (play_index_q),
		.rd_data (byte_s1)
	);

	wtg_sine_rom #(
		.WAVE_LENGTH (WAVE_LENGTH)
	) u_sine (
		.clk     (clk),
		.rd_en   (tick_accept),
		.rd_addr (next_index),
		.rd_data (sine_s1)
	);

	// shared multiplier operands, fetch stage
	assign rise_now = CNT_W'(idx_s1) < dix;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (wave_type_q)
			wtg_pkg::SHAPE_SINE: begin
				mul_a = MA_W'(peak);
				mul_b = MB_W'(sine_s1);
			end
			wtg_pkg::SHAPE_TRIANGLE: begin
				mul_a = rise_now ? MA_W'(idx_s1) : MA_W'(CNT_W'(idx_s1) - dix);
				mul_b = $signed(MB_W'(peak));
			end
			wtg_pkg::SHAPE_ARBITRARY: begin
				mul_a = MA_W'(byte_s1);
				mul_b = $signed(MB_W'(amp_c));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = $signed({1'b0, mul_a}) * mul_b;

	// trigger window compared in scaled form, no wrap
	assign idx_ext = TRIG_W'(idx_s1);
	assign phase_x = TRIG_W'(deg_c) * TRIG_W'(WAVE_LENGTH);
	assign low_ok  = (idx_ext + 1'b1) * TRIG_W'(wtg_pkg::DEG_FULL) > phase_x;
	assign high_ok = (idx_ext < TRIG_W'(wtg_pkg::TRIGGER_WIDTH))
		|| ((idx_ext - TRIG_W'(wtg_pkg::TRIGGER_WIDTH)) * TRIG_W'(wtg_pkg::DEG_FULL)
			<= phase_x);

	// sine: ceiling of the scaled value around mid level, limited to 0..peak
	assign total  = TOT_W'(prod_s2) + $signed(TOT_W'({peak[7:1], 16'h0000}));
	assign ceil_v = (total + CEIL_BIAS) >>> 16;

	always_comb begin
		if (total[TOT_W-1] || (total == '0)) begin
			sine_duty = '0;
		end else if (ceil_v > $signed(TOT_W'(peak))) begin
			sine_duty = peak;
		end else begin
			sine_duty = ceil_v[7:0];
		end
	end

	// arbitrary: sample times amplitude over full scale by reciprocal multiply
	assign arb_scaled = ARB_W'(prod_s2[wtg_pkg::ARB_NUM_W-1:0])
		* ARB_W'(wtg_pkg::ARB_RECIP);
	assign arb_duty   = arb_scaled[wtg_pkg::ARB_RECIP_SHIFT +: 8];

	always_comb begin
		case (wave_type_q)
			wtg_pkg::SHAPE_SINE:      direct_duty = sine_duty;
			wtg_pkg::SHAPE_SQUARE:    direct_duty = rise_s2 ? peak : '0;
			wtg_pkg::SHAPE_ARBITRARY: direct_duty = arb_duty;
			default:                  direct_duty = '0;
		endcase
	end

	// divider operands: rise or fall slope
	assign div_num = prod_s2[NUM_W-1:0];

	always_comb begin
		if (rise_s2) begin
			div_den = DEN_W'(dix);
		end else begin
			div_den = DEN_W'(CNT_W'(WAVE_LENGTH) - dix);
		end
	end

	assign div_duty = (is_tri && !rise_s2) ? peak - div_quo[7:0] : div_quo[7:0];

	wtg_divider #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_num),
		.denom    (div_den),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// sequencer next state
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			wtg_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid && (item.operation == wtg_pkg::OP_TICK)) begin
					state_d = wtg_pkg::ST_FETCH;
				end
			end
			wtg_pkg::ST_FETCH: begin
				state_d = wtg_pkg::ST_CALC;
			end
			wtg_pkg::ST_CALC: begin
				if (is_tri) begin
					div_start = 1'b1;
					state_d   = wtg_pkg::ST_DIVIDE;
				end else begin
					state_d = wtg_pkg::ST_DONE;
				end
			end
			wtg_pkg::ST_DIVIDE: begin
				if (!div_busy) begin
					state_d = wtg_pkg::ST_DONE;
				end
			end
			wtg_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = wtg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wtg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wtg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// play position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_index_q <= '0;
		end else if (tick_accept) begin
			play_index_q <= next_index;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q     <= wtg_pkg::SHAPE_OFF;
			amplitude_q     <= '0;
			duty_percent_q  <= wtg_pkg::DUTY_RESET;
			phase_degrees_q <= '0;
		end else if (cfg_accept) begin
			case (cfg_index)
				wtg_pkg::REG_WAVE_TYPE:     wave_type_q     <= cfg_data[2:0];
				wtg_pkg::REG_AMPLITUDE:     amplitude_q     <= cfg_data[5:0];
				wtg_pkg::REG_DUTY_PERCENT:  duty_percent_q  <= cfg_data[6:0];
				wtg_pkg::REG_PHASE_DEGREES: phase_degrees_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (tick_accept) begin
			idx_s1 <= play_index_q;
		end
		if (state_q == wtg_pkg::ST_FETCH) begin
			rise_s2 <= rise_now;
			trig_s2 <= low_ok && high_ok;
			prod_s2 <= mul_p;
		end
		if (state_q == wtg_pkg::ST_CALC) begin
			duty_s3 <= direct_duty;
		end
		if ((state_q == wtg_pkg::ST_DIVIDE) && !div_busy) begin
			duty_s3 <= div_duty;
		end
		if ((state_q == wtg_pkg::ST_DONE) && out_free) begin
			result_q.duty_value <= duty_s3;
			result_q.trigger    <= trig_s2;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((state_q == wtg_pkg::ST_DONE) && out_free) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	`WTG_ASSERT(ast_div_den, div_start, div_den != '0, "divider started with zero divisor")
	`WTG_ASSERT(ast_result_src, $rose(result_valid_q), $past(state_q) == wtg_pkg::ST_DONE,
		"result raised outside the done step")
	`WTG_ASSERT(ast_duty_peak, (state_q == wtg_pkg::ST_DONE) && !is_arb, duty_s3 <= peak,
		"duty count above peak")
	`WTG_ASSERT_NEXT(ast_load_idle, item_accept && (item.operation != wtg_pkg::OP_TICK),
		state_q == wtg_pkg::ST_IDLE, "load or restart left the idle step")

endmodule

`default_nettype wire
